/* hw/rtl/tcc_pkg.sv */
// Shared types and constants of the text console cursor writer.
`timescale 1ns / 1ps

package tcc_pkg;

	localparam int OP_W     = 3;
	localparam int CHAR_W   = 8;
	localparam int ATTR_W   = 8;
	localparam int POSX_W   = 7;
	localparam int POSY_W   = 5;
	localparam int CELL_W   = 16;
	localparam int OUTROW_W = 5;
	localparam int OUTCOL_W = 7;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [OP_W-1:0] OP_PUT        = 3'd0;
	localparam logic [OP_W-1:0] OP_WRITE_CELL = 3'd1;
	localparam logic [OP_W-1:0] OP_SET_CURSOR = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_CELL  = 3'd4;

	localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'd32;
	localparam logic [CELL_W-1:0] RESET_CELL   = 16'h1F20;

	// Work that the back end carries out for one transaction.
	typedef enum logic [2:0] {
		K_NOP,
		K_WRITE,
		K_READ,
		K_SCROLL,
		K_CLEAR
	} kind_t;

	typedef struct packed {
		logic [OUTROW_W-1:0] cursor_row;
		logic [OUTCOL_W-1:0] cursor_col;
		logic                scrolled;
	} res_t;

	typedef struct packed {
		kind_t             kind;
		logic              has_char;
		logic [CHAR_W-1:0] char_code;
		logic [ATTR_W-1:0] colour;
		res_t              res;
	} cmd_t;

endpackage

/* hw/rtl/tcc_if.sv */
// Request and response channel interfaces of the text console cursor writer.
`timescale 1ns / 1ps

interface tcc_in_if import tcc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [CHAR_W-1:0] char_code;
	logic [ATTR_W-1:0] colour;
	logic [POSX_W-1:0] pos_x;
	logic [POSY_W-1:0] pos_y;

	modport source (output valid, op, char_code, colour, pos_x, pos_y, input ready);
	modport sink (input valid, op, char_code, colour, pos_x, pos_y, output ready);
endinterface

interface tcc_out_if import tcc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CELL_W-1:0]   cell_res;
	logic [OUTROW_W-1:0] cursor_row_out;
	logic [OUTCOL_W-1:0] cursor_col_out;
	logic                scrolled;

	modport source (output valid, cell_res, cursor_row_out, cursor_col_out, scrolled,
		input ready);
	modport sink (input valid, cell_res, cursor_row_out, cursor_col_out, scrolled,
		output ready);
endinterface

/* hw/rtl/tcc_fifo.sv */
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module tcc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CNTW-1:0]  count_q;

	assign full     = (count_q == CNTW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/tcc_front.sv */
// Front end: accepts requests, owns the cursor and the ring origin, issues commands.
`timescale 1ns / 1ps

module tcc_front import tcc_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	localparam int AW = $clog2(COLUMNS * ROWS)
) (
	input  logic          clk,
	input  logic          arst_n,
	tcc_in_if.sink        req,
	input  logic          q_full,
	input  logic          init_done,
	output logic          push,
	output cmd_t          cmd,
	output logic [AW-1:0] addr
);

	localparam int CW = $clog2(COLUMNS + 1);
	localparam int RW = $clog2(ROWS);

	logic [RW-1:0] row_q, row_n;
	logic [CW-1:0] col_q, col_n;
	logic [RW-1:0] top_q, top_n;

	kind_t         kind;
	logic          has_char;
	logic          scroll;
	logic [RW-1:0] tgt_row;
	logic [CW-1:0] tgt_col;
	logic          in_range;
	logic [RW:0]   row_sum;
	logic [RW-1:0] phys_row;

	assign req.ready = init_done && !q_full;
	assign push      = req.valid && req.ready;
	assign in_range  = (32'(req.pos_x) < COLUMNS) && (32'(req.pos_y) < ROWS);

	always_comb begin
		row_n    = row_q;
		col_n    = col_q;
		top_n    = top_q;
		kind     = K_NOP;
		has_char = 1'b0;
		scroll   = 1'b0;
		tgt_row  = row_q;
		tgt_col  = col_q;
		unique case (req.op)
			OP_PUT: begin
				if ((32'(col_q) >= COLUMNS) || (req.char_code == CODE_NEWLINE)) begin
					col_n = '0;
					if (32'(row_q) >= ROWS - 1) begin
						row_n  = RW'(ROWS - 1);
						scroll = 1'b1;
						top_n  = (32'(top_q) == ROWS - 1) ? '0 : top_q + 1'b1;
					end else begin
						row_n = row_q + 1'b1;
					end
				end
				tgt_row = row_n;
				tgt_col = col_n;
				if (req.char_code != CODE_NEWLINE) begin
					has_char = 1'b1;
					col_n    = col_n + 1'b1;
				end
				if (scroll) begin
					kind = K_SCROLL;
				end else if (has_char) begin
					kind = K_WRITE;
				end
			end
			OP_WRITE_CELL: begin
				tgt_row = RW'(req.pos_y);
				tgt_col = CW'(req.pos_x);
				if (in_range) begin
					kind = K_WRITE;
				end
			end
			OP_SET_CURSOR: begin
				col_n = (32'(req.pos_x) > COLUMNS) ? CW'(COLUMNS) : CW'(req.pos_x);
				row_n = (32'(req.pos_y) > ROWS - 1) ? RW'(ROWS - 1) : RW'(req.pos_y);
			end
			OP_CLEAR: begin
				kind  = K_CLEAR;
				row_n = '0;
				col_n = '0;
				top_n = '0;
			end
			OP_READ_CELL: begin
				tgt_row = RW'(req.pos_y);
				tgt_col = CW'(req.pos_x);
				if (in_range) begin
					kind = K_READ;
				end
			end
			default: begin
			end
		endcase
	end

	// The screen is a ring of rows; logical row r lives at physical row (r + top) mod ROWS.
	// On a scroll the bottom logical row lands on the old top row, which the back end blanks.
	always_comb begin
		row_sum  = {1'b0, tgt_row} + {1'b0, top_q};
		phys_row = (32'(row_sum) >= ROWS) ? RW'(32'(row_sum) - ROWS) : RW'(row_sum);
		if (scroll) begin
			phys_row = top_q;
			addr     = AW'(32'(phys_row) * COLUMNS);
		end else begin
			addr = AW'(32'(phys_row) * COLUMNS) + AW'(tgt_col);
		end
	end

	always_comb begin
		cmd.kind           = kind;
		cmd.has_char       = has_char;
		cmd.char_code      = req.char_code;
		cmd.colour         = req.colour;
		cmd.res.cursor_row = OUTROW_W'(row_n);
		cmd.res.cursor_col = OUTCOL_W'(col_n);
		cmd.res.scrolled   = scroll;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			top_q <= '0;
		end else if (push) begin
			row_q <= row_n;
			col_q <= col_n;
			top_q <= top_n;
		end
	end

endmodule

/* hw/rtl/tcc_back.sv */
// Back end: owns the screen memory and executes writes, reads, row blanking and clears.
`timescale 1ns / 1ps

module tcc_back import tcc_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	localparam int AW = $clog2(COLUMNS * ROWS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  cmd_t          q_cmd,
	input  logic [AW-1:0] q_addr,
	output logic          pop,
	output logic          init_done,
	tcc_out_if.source     rsp
);

	localparam int CELLS = COLUMNS * ROWS;

	typedef enum logic {
		S_IDLE,
		S_SWEEP
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     swp_q;
	logic [AW-1:0]     last_q;
	logic [CELL_W-1:0] fill_q;
	logic [CELL_W-1:0] chr_q;
	logic [AW-1:0]     chr_addr_q;
	logic              chr_en_q;
	logic              init_q;
	logic              out_valid_q;
	logic              read_q;
	res_t              res_q;

	logic [CELL_W-1:0] mem_q [CELLS];
	logic [CELL_W-1:0] rd_data_q;

	logic              we;
	logic              re;
	logic [AW-1:0]     waddr;
	logic [CELL_W-1:0] wdata;

	assign pop       = (state_q == S_IDLE) && !q_empty && (!out_valid_q || rsp.ready);
	assign init_done = !init_q;
	assign re        = pop && (q_cmd.kind == K_READ);

	always_comb begin
		if (state_q == S_SWEEP) begin
			we    = 1'b1;
			waddr = swp_q;
			wdata = (chr_en_q && (swp_q == chr_addr_q)) ? chr_q : fill_q;
		end else begin
			we    = pop && (q_cmd.kind == K_WRITE);
			waddr = q_addr;
			wdata = {q_cmd.colour, q_cmd.char_code};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem_q[q_addr];
		end
	end

	// Reset starts with a sweep of the whole memory that writes the blank cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			swp_q       <= '0;
			last_q      <= AW'(CELLS - 1);
			fill_q      <= RESET_CELL;
			chr_q       <= '0;
			chr_addr_q  <= '0;
			chr_en_q    <= 1'b0;
			init_q      <= 1'b1;
			out_valid_q <= 1'b0;
			read_q      <= 1'b0;
			res_q       <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						res_q  <= q_cmd.res;
						read_q <= (q_cmd.kind == K_READ);
						case (q_cmd.kind)
							K_SCROLL: begin
								state_q    <= S_SWEEP;
								swp_q      <= q_addr;
								last_q     <= q_addr + AW'(COLUMNS - 1);
								fill_q     <= {q_cmd.colour, CODE_SPACE};
								chr_q      <= {q_cmd.colour, q_cmd.char_code};
								chr_addr_q <= q_addr;
								chr_en_q   <= q_cmd.has_char;
							end
							K_CLEAR: begin
								state_q  <= S_SWEEP;
								swp_q    <= '0;
								last_q   <= AW'(CELLS - 1);
								fill_q   <= {q_cmd.colour, CODE_SPACE};
								chr_en_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				S_SWEEP: begin
					if (swp_q == last_q) begin
						state_q <= S_IDLE;
						init_q  <= 1'b0;
					end else begin
						swp_q <= swp_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.cell_res       = read_q ? rd_data_q : '0;
	assign rsp.cursor_row_out = res_q.cursor_row;
	assign rsp.cursor_col_out = res_q.cursor_col;
	assign rsp.scrolled       = res_q.scrolled;

endmodule

/* hw/rtl/text_console_cursor_writer.sv */
// Text console writer: a COLUMNS x ROWS screen of character cells and a cursor.
//
// Requests arrive on req (op, char_code, colour, pos_x, pos_y) and each one gives exactly
// one transaction on rsp (cell_res, cursor_row_out, cursor_col_out, scrolled), in order.
// The front end updates the cursor and accepts one request per cycle, while the queue has
// room, into a four-entry command queue; the back end owns the screen memory (one write
// and one read port). An accepted request is registered in the queue, and its response
// in the back end's output register. Put without a scroll, write cell, set cursor and
// read cell do not hold the back end, so they sustain one transaction per cycle while rsp
// is not stalled. The screen is a ring of rows, so a scroll only blanks one row and holds
// the back end while it sweeps that row; a clear holds it while it sweeps all memory.
// While the back end is busy the queue fills and req stalls when it is full.
// After reset the memory is swept to blank white-on-blue cells; req.ready stays low
// during that sweep. The cursor starts at row 0, column 0.
// When rsp is stalled the response holds in its output register and the queue absorbs up
// to four more requests before req.ready drops.
`timescale 1ns / 1ps

module text_console_cursor_writer import tcc_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  logic      clk,
	input  logic      arst_n,
	tcc_in_if.sink    req,
	tcc_out_if.source rsp
);

	localparam int AW = $clog2(COLUMNS * ROWS);
	localparam int QW = $bits(cmd_t) + AW;

	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_empty;
	logic          init_done;
	cmd_t          f_cmd;
	logic [AW-1:0] f_addr;
	cmd_t          q_cmd;
	logic [AW-1:0] q_addr;
	logic [QW-1:0] q_data;

	tcc_front #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.q_full(q_full),
		.init_done(init_done),
		.push(push),
		.cmd(f_cmd),
		.addr(f_addr)
	);

	tcc_fifo #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({f_cmd, f_addr}),
		.pop(pop),
		.pop_data(q_data),
		.full(q_full),
		.empty(q_empty)
	);

	assign {q_cmd, q_addr} = q_data;

	tcc_back #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_cmd(q_cmd),
		.q_addr(q_addr),
		.pop(pop),
		.init_done(init_done),
		.rsp(rsp)
	);

endmodule

/* hw/rtl/tcc_checker.sv */
// Port-level checks on the text console cursor writer, bound to its top level.
`timescale 1ns / 1ps

module tcc_checker import tcc_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [CELL_W-1:0]   cell_res,
	input logic [OUTROW_W-1:0] cursor_row_out,
	input logic [OUTCOL_W-1:0] cursor_col_out,
	input logic                scrolled
);

	// A response is held until the transaction completes.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(cell_res) && $stable(cursor_row_out)
			&& $stable(cursor_col_out) && $stable(scrolled))
		else $error("response changed while stalled");

	// The cursor never leaves the screen; the column may pass the last column only to the pending-wrap place.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(cursor_col_out) <= COLUMNS) && (32'(cursor_row_out) < ROWS))
		else $error("cursor out of range");

	// A scroll leaves the cursor at the start of the last row, one past it after a character.
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && scrolled |-> (32'(cursor_row_out) == ROWS - 1)
			&& (cursor_col_out == '0 || cursor_col_out == OUTCOL_W'(1)))
		else $error("cursor misplaced after scroll");

endmodule

bind text_console_cursor_writer tcc_checker #(
	.COLUMNS(COLUMNS),
	.ROWS(ROWS)
) u_tcc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.cell_res(rsp.cell_res),
	.cursor_row_out(rsp.cursor_row_out),
	.cursor_col_out(rsp.cursor_col_out),
	.scrolled(rsp.scrolled)
);
